[hw/rtl/qpt_pkg.sv]
// qpt_pkg: types, constants and the microcode table of the quintic ping-pong trajectory block.
// Used by qpt_sequencer, qpt_datapath and quintic_pingpong_trajectory; depends on nothing.
package qpt_pkg;

    localparam int unsigned FRAC = 24;
    localparam logic [24:0] ONE_Q24 = 25'h1000000;
    localparam logic [24:0] TAU_STEP_RESET = 25'd839;
    localparam logic [2:0] ADDR_TAU_STEP = 3'd0;
    localparam int unsigned PC_W = 4;

    typedef logic [PC_W-1:0] qpt_pc_t;

    localparam qpt_pc_t STEP_IDLE   = 4'd0;
    localparam qpt_pc_t STEP_SQ     = 4'd1;
    localparam qpt_pc_t STEP_T2     = 4'd2;
    localparam qpt_pc_t STEP_CUBE   = 4'd3;
    localparam qpt_pc_t STEP_T3     = 4'd4;
    localparam qpt_pc_t STEP_BLEND  = 4'd5;
    localparam qpt_pc_t STEP_ALPHA  = 4'd6;
    localparam qpt_pc_t STEP_STREAM = 4'd7;
    localparam qpt_pc_t STEP_FINISH = 4'd8;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_END,
        CMD_ORIGIN
    } qpt_cmd_t;

    typedef enum logic [1:0] {
        MUL_TT,
        MUL_T2T,
        MUL_T3P,
        MUL_POSE
    } qpt_mul_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_NOTICK,
        JMP_BUSY,
        JMP_ALWAYS
    } qpt_jmp_t;

    typedef struct packed {
        qpt_cmd_t           cmd;
        logic [5:0]         joint_index;
        logic signed [31:0] joint_value;
    } qpt_in_t;

    typedef struct packed {
        logic [5:0]         out_joint;
        logic signed [31:0] reference;
        logic               last;
        logic               reversing;
    } qpt_out_t;

    typedef struct packed {
        logic     accept;
        logic     init;
        logic     mul_en;
        qpt_mul_t mul_sel;
        logic     ld_t2;
        logic     ld_poly;
        logic     ld_t3;
        logic     ld_alpha;
        logic     stream;
        logic     finish;
        qpt_jmp_t jmp;
        qpt_pc_t  target;
    } qpt_ctl_t;

    typedef struct packed {
        logic tick_acc;
        logic busy;
    } qpt_stat_t;

    function automatic qpt_ctl_t qpt_rom(input qpt_pc_t pc);
        qpt_ctl_t w;
        w = '0;
        w.mul_sel = MUL_TT;
        w.jmp = JMP_NONE;
        w.target = STEP_IDLE;
        case (pc)
            STEP_IDLE: begin
                w.accept = 1'b1;
                w.jmp = JMP_NOTICK;
                w.target = STEP_IDLE;
            end
            STEP_SQ: begin
                w.init = 1'b1;
                w.mul_en = 1'b1;
                w.mul_sel = MUL_TT;
            end
            STEP_T2: begin
                w.ld_t2 = 1'b1;
            end
            STEP_CUBE: begin
                w.mul_en = 1'b1;
                w.mul_sel = MUL_T2T;
                w.ld_poly = 1'b1;
            end
            STEP_T3: begin
                w.ld_t3 = 1'b1;
            end
            STEP_BLEND: begin
                w.mul_en = 1'b1;
                w.mul_sel = MUL_T3P;
            end
            STEP_ALPHA: begin
                w.ld_alpha = 1'b1;
            end
            STEP_STREAM: begin
                w.stream = 1'b1;
                w.mul_en = 1'b1;
                w.mul_sel = MUL_POSE;
                w.jmp = JMP_BUSY;
                w.target = STEP_STREAM;
            end
            STEP_FINISH: begin
                w.finish = 1'b1;
                w.jmp = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
            default: begin
                w.jmp = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/qpt_sequencer.sv]
// qpt_sequencer: step counter over the microcode table, with conditional jumps.
// Depends on qpt_pkg for the control word, status struct and table.
module qpt_sequencer
    import qpt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  qpt_stat_t stat,
    output qpt_ctl_t  ctl
);

    qpt_pc_t pc_reg;
    qpt_pc_t pc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    always_comb begin
        ctl = qpt_rom(pc_reg);
        case (ctl.jmp)
            JMP_NONE:   pc_next = pc_reg + 1'b1;
            JMP_NOTICK: pc_next = stat.tick_acc ? pc_reg + 1'b1 : ctl.target;
            JMP_BUSY:   pc_next = stat.busy ? ctl.target : pc_reg + 1'b1;
            JMP_ALWAYS: pc_next = ctl.target;
            default:    pc_next = STEP_IDLE;
        endcase
    end

endmodule

[hw/rtl/qpt_datapath.sv]
// qpt_datapath: pose memories, shared multiplier, blend registers and the joint pipeline.
// Depends on qpt_pkg; driven by the control word from qpt_sequencer.
module qpt_datapath
    import qpt_pkg::*;
#(
    parameter int JOINTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  qpt_ctl_t    ctl,
    input  logic [24:0] tau_step,
    input  logic        s_valid,
    input  qpt_in_t     s_data,
    output qpt_stat_t   stat,
    output logic        m_valid,
    input  logic        m_ready,
    output qpt_out_t    m_data
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int CW = $clog2(JOINTS + 1);

    logic signed [31:0] start_mem [JOINTS];
    logic signed [31:0] end_mem [JOINTS];
    logic signed [31:0] org_mem [JOINTS];

    logic [25:0] phase_reg;
    logic        toward_reg;
    logic        flip_reg;
    logic [24:0] t2_reg;
    logic [24:0] t3_reg;
    logic [27:0] poly_reg;
    logic [24:0] alpha_reg;
    logic signed [62:0] prod_reg;
    logic [CW-1:0] icnt_reg;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [JW-1:0] j1_reg, j2_reg, j3_reg, j4_reg;
    logic signed [31:0] st1_reg, en1_reg, or1_reg;
    logic signed [32:0] d2_reg;
    logic signed [31:0] org2_reg, org3_reg, org4_reg;
    logic signed [33:0] q4_reg;

    logic     m_valid_reg;
    qpt_out_t m_data_reg;

    logic        in_acc;
    logic        wr_ok;
    logic [JW-1:0] wr_addr;
    logic [24:0] tc;
    logic [29:0] poly_full;
    logic signed [33:0] mul_a;
    logic signed [28:0] mul_b;
    logic signed [62:0] prod_rnd;
    logic signed [62:0] shifted;
    logic adv;
    logic issue;
    logic [JW-1:0] ia;
    logic signed [34:0] r_full;
    logic signed [31:0] r_sat;

    assign in_acc  = s_valid && ctl.accept && aresetn;
    assign wr_ok   = in_acc && (s_data.cmd != CMD_TICK) && (7'(s_data.joint_index) < 7'(JOINTS));
    assign wr_addr = s_data.joint_index[JW-1:0];

    assign tc = (phase_reg >= 26'(ONE_Q24)) ? ONE_Q24 : phase_reg[24:0];
    assign poly_full = 30'(t2_reg) * 30'd6 + 30'h0A000000 - 30'(tc) * 30'd15;

    always_comb begin
        case (ctl.mul_sel)
            MUL_TT: begin
                mul_a = {9'b0, tc};
                mul_b = {4'b0, tc};
            end
            MUL_T2T: begin
                mul_a = {9'b0, t2_reg};
                mul_b = {4'b0, tc};
            end
            MUL_T3P: begin
                mul_a = {9'b0, t3_reg};
                mul_b = {1'b0, poly_reg};
            end
            MUL_POSE: begin
                mul_a = {d2_reg[32], d2_reg};
                mul_b = {4'b0, alpha_reg};
            end
            default: begin
                mul_a = {9'b0, tc};
                mul_b = {4'b0, tc};
            end
        endcase
    end

    assign prod_rnd = prod_reg + 63'sh800000;
    assign shifted  = prod_rnd >>> FRAC;

    assign adv   = !(m_valid_reg && !m_ready);
    assign issue = ctl.stream && adv && (icnt_reg < CW'(JOINTS));
    assign ia    = icnt_reg[JW-1:0];

    assign r_full = {{3{org4_reg[31]}}, org4_reg} + {q4_reg[33], q4_reg};

    always_comb begin
        if (r_full[34:31] == 4'b0000 || r_full[34:31] == 4'b1111) begin
            r_sat = r_full[31:0];
        end else if (r_full[34]) begin
            r_sat = 32'sh80000000;
        end else begin
            r_sat = 32'sh7FFFFFFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok && s_data.cmd == CMD_START) begin
            start_mem[wr_addr] <= s_data.joint_value;
        end
        if (wr_ok && s_data.cmd == CMD_END) begin
            end_mem[wr_addr] <= s_data.joint_value;
        end
        if (wr_ok && s_data.cmd == CMD_ORIGIN) begin
            org_mem[wr_addr] <= s_data.joint_value;
        end else if (adv && v4_reg && flip_reg) begin
            org_mem[j4_reg] <= r_sat;
        end
        if (issue) begin
            st1_reg <= start_mem[ia];
            en1_reg <= end_mem[ia];
            or1_reg <= org_mem[ia];
            j1_reg  <= ia;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            toward_reg  <= 1'b0;
            icnt_reg    <= CW'(JOINTS);
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_acc && s_data.cmd == CMD_ORIGIN) begin
                phase_reg <= '0;
            end else if (ctl.finish) begin
                if (flip_reg) begin
                    phase_reg  <= '0;
                    toward_reg <= !toward_reg;
                end else begin
                    phase_reg <= phase_reg + {1'b0, tau_step};
                end
            end
            if (ctl.init) begin
                icnt_reg <= '0;
            end else if (issue) begin
                icnt_reg <= icnt_reg + 1'b1;
            end
            if (adv) begin
                v1_reg      <= issue;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                v4_reg      <= v3_reg;
                m_valid_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.init) begin
            flip_reg <= (phase_reg >= 26'(ONE_Q24));
        end
        if (ctl.ld_t2) begin
            t2_reg <= shifted[24:0];
        end
        if (ctl.ld_poly) begin
            poly_reg <= poly_full[27:0];
        end
        if (ctl.ld_t3) begin
            t3_reg <= shifted[24:0];
        end
        if (ctl.ld_alpha) begin
            alpha_reg <= (shifted[38:0] > 39'(ONE_Q24)) ? ONE_Q24 : shifted[24:0];
        end
        if (ctl.mul_en && (!ctl.stream || adv)) begin
            prod_reg <= mul_a * mul_b;
        end
        if (adv && v1_reg) begin
            d2_reg   <= (toward_reg ? {en1_reg[31], en1_reg} : {st1_reg[31], st1_reg})
                        - {or1_reg[31], or1_reg};
            org2_reg <= or1_reg;
            j2_reg   <= j1_reg;
        end
        if (adv && v2_reg) begin
            org3_reg <= org2_reg;
            j3_reg   <= j2_reg;
        end
        if (adv && v3_reg) begin
            q4_reg   <= shifted[33:0];
            org4_reg <= org3_reg;
            j4_reg   <= j3_reg;
        end
        if (adv && v4_reg) begin
            m_data_reg.out_joint <= 6'(j4_reg);
            m_data_reg.reference <= r_sat;
            m_data_reg.last      <= (j4_reg == JW'(JOINTS - 1));
            m_data_reg.reversing <= flip_reg;
        end
    end

    assign stat.tick_acc = in_acc && (s_data.cmd == CMD_TICK);
    assign stat.busy     = (icnt_reg < CW'(JOINTS)) || v1_reg || v2_reg || v3_reg || v4_reg;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

endmodule

[hw/rtl/quintic_pingpong_trajectory.sv]
// quintic_pingpong_trajectory: top level with the APB register, sequencer and datapath.
// Depends on qpt_pkg, qpt_sequencer and qpt_datapath.
//
// Usage: the s_ channel takes one command transaction at a time: a tick, or a write of a
// joint's start pose, end pose or segment origin (the origin write also restarts time).
// A write yields nothing; writes to joints at or above JOINTS are dropped.
// A tick yields JOINTS result transactions on the m_ channel, joints in ascending order,
// last set on the final one, reversing set on every one of a tick that ends the motion.
// A tick runs in order: the blend polynomial, three products through the one shared
// multiplier, then one joint per cycle while the receiver is ready through the memory read,
// subtract, multiply, round and saturate stages, and a drain and finish step; the next
// command is taken only once the finish step is done.
// A stalled receiver freezes the joint pipeline; no result is lost or repeated.
// tau_step sits at byte address 0 of the APB port; write it only while the block is idle.
// Reset: s_ready drops, phase returns to zero, direction to the start pose, tau_step to 839;
// the pose memories are not cleared and must be written before the first tick.
module quintic_pingpong_trajectory
    import qpt_pkg::*;
#(
    parameter int JOINTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  qpt_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output qpt_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [24:0] tau_step_reg;
    logic [24:0] tau_step_next;
    qpt_ctl_t    ctl;
    qpt_stat_t   stat;

    assign pready = 1'b1;

    always_comb begin
        tau_step_next = tau_step_reg;
        if (psel && penable && pwrite && pready && paddr == ADDR_TAU_STEP) begin
            tau_step_next = pwdata[24:0];
        end
        prdata = (paddr == ADDR_TAU_STEP) ? {7'b0, tau_step_reg} : 32'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_step_reg <= TAU_STEP_RESET;
        end else begin
            tau_step_reg <= tau_step_next;
        end
    end

    qpt_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctl     (ctl)
    );

    qpt_datapath #(
        .JOINTS (JOINTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .tau_step (tau_step_reg),
        .s_valid  (s_valid),
        .s_data   (s_data),
        .stat     (stat),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign s_ready = ctl.accept && aresetn;

endmodule
